@@ sv/glyph_texel_format_converter_assert.svh @@
// Assertion macros for the glyph texel converter top level.
// Expects signals clk and rst in the including module's scope.
`ifndef GLYPH_TEXEL_FORMAT_CONVERTER_ASSERT_SVH
`define GLYPH_TEXEL_FORMAT_CONVERTER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define GTFC_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define GTFC_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/gtfc_pkg.sv @@
// Shared types and constants for the glyph texel format converter.
// No dependencies; used by the interfaces, the gradient unit and the top level.
package gtfc_pkg;

  localparam int PIX_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int BRIGHT_W  = 7;
  localparam int LUM_W     = 12;  // 11*31 + 59*31 + 30*31 = 3100
  localparam int PROD_W    = 19;  // 3100 * 127 = 393700
  localparam int SCALED_W  = 12;  // (32000 * 255) >> 11 = 3984
  localparam int GREY_W    = 5;

  typedef enum logic [1:0] {
    MODE_MONO     = 2'd0,
    MODE_COL565   = 2'd1,
    MODE_PASS4444 = 2'd2,
    MODE_GRAD     = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 2'd0,
    CFG_BRIGHTNESS = 2'd1,
    CFG_MONO_COLOR = 2'd2
  } cfg_idx_t;

  localparam logic [PIX_W-1:0]    KEY_GREEN   = 16'h07E0;
  localparam logic [PIX_W-1:0]    MONO_RESET  = 16'hFFFF;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd10;
  localparam logic [PROD_W-1:0]   FULL_SCALE  = 19'd32000;

  // floor(y / 125) == (y * 4195) >> 19 for every y below 4096
  localparam int                  RECIP_SHIFT = 19;
  localparam logic [12:0]         RECIP_125   = 13'd4195;
  localparam int                  DIV_SHIFT   = 11;  // 256000 = 125 << 11

endpackage

@@ sv/gtfc_texel_if.sv @@
// Input channel carrying one glyph texel per beat.
// Depends on gtfc_pkg for the field width.
interface gtfc_texel_if;
  logic                        valid;
  logic                        ready;
  logic [gtfc_pkg::PIX_W-1:0]  texel;

  modport source (output valid, output texel, input ready);
  modport sink   (input valid, input texel, output ready);
endinterface

@@ sv/gtfc_pixel_if.sv @@
// Output channel carrying one converted surface pixel per beat.
// Depends on gtfc_pkg for the field width.
interface gtfc_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [gtfc_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

@@ sv/gtfc_grad.sv @@
// Pipelined grey level datapath: luminance, brightness scale, divide by full scale.
// Depends on gtfc_pkg; stage enables come from the top level's pipeline control.
module gtfc_grad (
  input  logic                            clk,
  input  logic [2:0]                      adv,
  input  logic [gtfc_pkg::PIX_W-1:0]      texel,
  input  logic [gtfc_pkg::BRIGHT_W-1:0]   brightness_tenths,
  output logic [gtfc_pkg::GREY_W-1:0]     grey
);

  logic [gtfc_pkg::LUM_W-1:0]     lum;
  logic [gtfc_pkg::LUM_W-1:0]     lum_next;
  logic [gtfc_pkg::PROD_W-1:0]    prod;
  logic [22:0]                    prod_x255;
  logic [gtfc_pkg::SCALED_W-1:0]  scaled;
  logic                           sat;
  logic [24:0]                    quot_full;

  assign lum_next = gtfc_pkg::LUM_W'(texel[4:0])   * gtfc_pkg::LUM_W'(11)
                  + gtfc_pkg::LUM_W'(texel[10:6])  * gtfc_pkg::LUM_W'(59)
                  + gtfc_pkg::LUM_W'(texel[15:11]) * gtfc_pkg::LUM_W'(30);

  assign prod_x255 = 23'(prod) * 23'd255;

  // Stage 1: luminance. Stage 2: scale. Stage 3: drop the power-of-two part
  // of the divisor and flag saturation.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      lum <= lum_next;
    end
    if (adv[1]) begin
      prod <= gtfc_pkg::PROD_W'(lum) * gtfc_pkg::PROD_W'(brightness_tenths);
    end
    if (adv[2]) begin
      sat    <= (prod > gtfc_pkg::FULL_SCALE);
      scaled <= prod_x255[gtfc_pkg::DIV_SHIFT +: gtfc_pkg::SCALED_W];
    end
  end

  // Divide by the odd part through the reciprocal; exact over the whole range
  assign quot_full = 25'(scaled) * 25'(gtfc_pkg::RECIP_125);
  assign grey      = sat ? {gtfc_pkg::GREY_W{1'b1}}
                         : quot_full[gtfc_pkg::RECIP_SHIFT +: gtfc_pkg::GREY_W];

endmodule

@@ sv/glyph_texel_format_converter.sv @@
// Glyph texel format converter, top level: config registers, pipeline control, output mux.
// Depends on gtfc_pkg, gtfc_texel_if, gtfc_pixel_if, gtfc_grad and the assertion header.
//
// Usage:
//   texel_ch (sink) takes one glyph texel per beat; pixel_ch (source) gives one
//   16-bit surface pixel per beat, in the same order, one pixel for each texel.
//   The cfg port writes mode, brightness_tenths and mono_color by index
//   (0, 1, 2) on any edge with cfg_we high; index 3 is ignored. Write config
//   only while no beat is in flight.
//   Path: the edge that accepts a texel loads stage 1; the beat then moves
//   through stages 2 and 3 into the output register, which raises pixel valid.
//   Throughput: one beat per cycle; four register stages (luminance, brightness
//   multiply, full-scale scaling, output mux) all advance together when nothing
//   blocks.
//   Stall: each stage holds while its successor is full and blocked, so an
//   empty stage still takes a beat; with the receiver stalled the block keeps
//   accepting until all four stages are full, then drops texel_ch.ready.
//   Nothing is lost or repeated.
//   Reset (rst, synchronous): empties the pipeline and loads mode = 565 to
//   1555, brightness_tenths = 10, mono_color = 0xFFFF.
module glyph_texel_format_converter (
  input  logic                              clk,
  input  logic                              rst,
  gtfc_texel_if.sink                        texel_ch,
  gtfc_pixel_if.source                      pixel_ch,
  input  logic                              cfg_we,
  input  logic [gtfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gtfc_pkg::PIX_W-1:0]        cfg_data
);

`include "glyph_texel_format_converter_assert.svh"

  // Configuration registers
  gtfc_pkg::mode_t                  mode;
  logic [gtfc_pkg::BRIGHT_W-1:0]    brightness_tenths;
  logic [gtfc_pkg::PIX_W-1:0]       mono_color;

  // Pipeline control: one valid per stage, stage 4 is the output register
  logic [4:1]                       stage_valid;
  logic [4:1]                       adv;

  // Texel travels alongside the gradient datapath
  logic [gtfc_pkg::PIX_W-1:0]       texel1;
  logic [gtfc_pkg::PIX_W-1:0]       texel2;
  logic [gtfc_pkg::PIX_W-1:0]       texel3;
  logic [gtfc_pkg::PIX_W-1:0]       pixel;
  logic [gtfc_pkg::PIX_W-1:0]       pixel_next;
  logic [gtfc_pkg::GREY_W-1:0]      grey;
  logic                             keyed;

  // Write config registers; ignore unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= gtfc_pkg::MODE_COL565;
      brightness_tenths <= gtfc_pkg::BRIGHT_RESET;
      mono_color        <= gtfc_pkg::MONO_RESET;
    end else if (cfg_we) begin
      unique case (gtfc_pkg::cfg_idx_t'(cfg_index))
        gtfc_pkg::CFG_MODE:       mode <= gtfc_pkg::mode_t'(cfg_data[1:0]);
        gtfc_pkg::CFG_BRIGHTNESS: brightness_tenths <= cfg_data[gtfc_pkg::BRIGHT_W-1:0];
        gtfc_pkg::CFG_MONO_COLOR: mono_color <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Advance a stage when it is empty or its successor advances; stage 4
  // advances when empty or when the receiver takes the beat.
  assign adv[4] = !stage_valid[4] || pixel_ch.ready;
  assign adv[3] = !stage_valid[3] || adv[4];
  assign adv[2] = !stage_valid[2] || adv[3];
  assign adv[1] = !stage_valid[1] || adv[2];

  assign texel_ch.ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (adv[1]) stage_valid[1] <= texel_ch.valid;
      if (adv[2]) stage_valid[2] <= stage_valid[1];
      if (adv[3]) stage_valid[3] <= stage_valid[2];
      if (adv[4]) stage_valid[4] <= stage_valid[3];
    end
  end

  // Carry the texel; hold payload while the stage is stalled
  always_ff @(posedge clk) begin
    if (adv[1]) texel1 <= texel_ch.texel;
    if (adv[2]) texel2 <= texel1;
    if (adv[3]) texel3 <= texel2;
    if (adv[4]) pixel  <= pixel_next;
  end

  gtfc_grad u_grad (
    .clk               (clk),
    .adv               (adv[3:1]),
    .texel             (texel_ch.texel),
    .brightness_tenths (brightness_tenths),
    .grey              (grey)
  );

  // Pure green is the color key for both 565 and gradient modes
  assign keyed = (texel3 == gtfc_pkg::KEY_GREEN);

  always_comb begin
    unique case (mode)
      gtfc_pkg::MODE_MONO:
        pixel_next = texel3[0] ? mono_color : '0;
      gtfc_pkg::MODE_COL565:
        // drop the low green bit, set alpha
        pixel_next = keyed ? '0 : {1'b1, texel3[15:11], texel3[10:6], texel3[4:0]};
      gtfc_pkg::MODE_PASS4444:
        pixel_next = texel3;
      gtfc_pkg::MODE_GRAD:
        pixel_next = keyed ? '0 : {1'b1, grey, grey, grey};
      default:
        pixel_next = texel3;
    endcase
  end

  assign pixel_ch.valid = stage_valid[4];
  assign pixel_ch.pixel = pixel;

  // An empty output stage means every stage can advance
  `GTFC_CHECK(a_empty_out_ready, (!stage_valid[4] |-> texel_ch.ready), "ready low with empty output stage")
  // An accepted beat always lands in stage 1
  `GTFC_CHECK(a_accept_lands, (texel_ch.valid && texel_ch.ready |=> stage_valid[1]), "accepted beat lost at stage 1")
  // Keyed texel in a keying mode gives a cleared pixel
  `GTFC_CHECK(a_key_clears, (adv[4] && stage_valid[3] && keyed && (mode == gtfc_pkg::MODE_COL565 || mode == gtfc_pkg::MODE_GRAD) |=> pixel == '0), "color key not cleared")
  // Non-keyed gradient pixels carry the alpha bit
  `GTFC_CHECK(a_grad_alpha, (adv[4] && stage_valid[3] && !keyed && mode == gtfc_pkg::MODE_GRAD |=> pixel[15]), "gradient pixel missing alpha")

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for glyph_texel_format_converter: directed and random texels
// in all four modes, random idling on both channels, pixels checked against a predictor.
// Depends on gtfc_pkg, gtfc_texel_if, gtfc_pixel_if and the converter RTL.
module testbench;

  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off that fills the pipeline
  localparam int IDLE_LIMIT    = 3000;  // cycles without any beat before giving up
  localparam int SETTLE_CYCLES = 8;     // pipeline is 4 deep; leave some margin
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 150;
  localparam int REPORT_LIMIT  = 100;

  // Predicts one pixel per accepted texel and holds the pixels still owed by the block.
  class expected_pixels;
    gtfc_pkg::mode_t                 mode;
    logic [gtfc_pkg::BRIGHT_W-1:0]   bright;
    logic [gtfc_pkg::PIX_W-1:0]      mono_color;
    logic [gtfc_pkg::PIX_W-1:0]      pixel_q[$];
    logic [gtfc_pkg::PIX_W-1:0]      texel_q[$];
    int                              errors;

    function new();
      mode       = gtfc_pkg::MODE_COL565;
      bright     = gtfc_pkg::BRIGHT_RESET;
      mono_color = gtfc_pkg::MONO_RESET;
      errors     = 0;
    endfunction

    function void write_reg(gtfc_pkg::cfg_idx_t idx, logic [gtfc_pkg::PIX_W-1:0] data);
      case (idx)
        gtfc_pkg::CFG_MODE:       mode = gtfc_pkg::mode_t'(data[1:0]);
        gtfc_pkg::CFG_BRIGHTNESS: bright = data[gtfc_pkg::BRIGHT_W-1:0];
        gtfc_pkg::CFG_MONO_COLOR: mono_color = data;
        default: ;
      endcase
    endfunction

    function logic [gtfc_pkg::PIX_W-1:0] convert_texel(logic [gtfc_pkg::PIX_W-1:0] t);
      int unsigned                   lum;
      int unsigned                   prod;
      int unsigned                   v8;
      logic [gtfc_pkg::GREY_W-1:0]   v;
      case (mode)
        gtfc_pkg::MODE_MONO:     return t[0] ? mono_color : '0;
        gtfc_pkg::MODE_PASS4444: return t;
        gtfc_pkg::MODE_COL565: begin
          if (t == gtfc_pkg::KEY_GREEN) return '0;
          // drop the low green bit, set alpha
          return {1'b1, t[15:11], t[10:6], t[4:0]};
        end
        default: begin
          if (t == gtfc_pkg::KEY_GREEN) return '0;
          lum  = 11 * t[4:0] + 59 * t[10:6] + 30 * t[15:11];
          prod = lum * bright;
          v8   = (prod > 32000) ? 255 : prod * 255 / 32000;
          v    = v8[7:3];
          return {1'b1, v, v, v};
        end
      endcase
    endfunction

    function void note_texel(logic [gtfc_pkg::PIX_W-1:0] t);
      pixel_q.push_back(convert_texel(t));
      texel_q.push_back(t);
    endfunction

    function void check_pixel(logic [gtfc_pkg::PIX_W-1:0] px);
      logic [gtfc_pkg::PIX_W-1:0] want;
      logic [gtfc_pkg::PIX_W-1:0] t;
      if (pixel_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected pixel, expected none, actual %h", $time, px);
        return;
      end
      want = pixel_q.pop_front();
      t    = texel_q.pop_front();
      if (px !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: pixel mismatch for texel %h (mode %s), expected %h, actual %h",
                   $time, t, mode.name(), want, px);
      end
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    function int report_leftover();
      foreach (pixel_q[i])
        $display("%0t: pixel never arrived for texel %h, expected %h, actual none",
                 $time, texel_q[i], pixel_q[i]);
      return pixel_q.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [gtfc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gtfc_pkg::PIX_W-1:0]      cfg_data;

  gtfc_texel_if texel_ch();
  gtfc_pixel_if pixel_ch();

  expected_pixels board = new();

  bit steady_flow = 1'b0;  // no idling on either side while set
  bit hold_req    = 1'b0;  // ask the receiver for one long hold-off
  int stall_left  = 0;
  int quiet_cycles = 0;

  glyph_texel_format_converter dut (
    .clk       (clk),
    .rst       (rst),
    .texel_ch  (texel_ch),
    .pixel_ch  (pixel_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length: mostly none, often a few cycles, now and then a long stretch.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one texel after an optional gap; return at the edge that takes the beat.
  // Leave valid high afterwards so back-to-back beats need no extra assignment.
  task automatic send_texel(input logic [gtfc_pkg::PIX_W-1:0] t, input int gap);
    if (gap > 0) begin
      texel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    texel_ch.valid <= 1'b1;
    texel_ch.texel <= t;
    do @(posedge clk); while (!texel_ch.ready);
    board.note_texel(t);
  endtask

  task automatic send_list(input logic [gtfc_pkg::PIX_W-1:0] list[$]);
    foreach (list[i])
      send_texel(list[i], steady_flow ? 0 : idle_len());
  endtask

  // Drop valid, wait until every owed pixel is back, then let the pipeline settle.
  task automatic wait_pipeline_empty();
    texel_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input gtfc_pkg::cfg_idx_t idx,
                         input logic [gtfc_pkg::PIX_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Write all three registers on consecutive edges; call only with the block idle.
  task automatic configure(input gtfc_pkg::mode_t m,
                           input logic [gtfc_pkg::BRIGHT_W-1:0] b,
                           input logic [gtfc_pkg::PIX_W-1:0] color);
    put_reg(gtfc_pkg::CFG_MODE, gtfc_pkg::PIX_W'(m));
    put_reg(gtfc_pkg::CFG_BRIGHTNESS, gtfc_pkg::PIX_W'(b));
    put_reg(gtfc_pkg::CFG_MONO_COLOR, color);
    cfg_we <= 1'b0;
  endtask

  // Receiver: check every pixel beat, then pick ready for the next edge.
  // Random stalls, none while steady_flow is set, and one long hold-off on request.
  initial begin
    pixel_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (pixel_ch.valid && pixel_ch.ready)
          board.check_pixel(pixel_ch.pixel);
        if (hold_req) begin
          hold_req   = 1'b0;
          stall_left = HOLD_CYCLES;
        end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 3) == 0) begin
          stall_left = idle_len();
        end
        if (stall_left > 0) begin
          pixel_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          pixel_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: give up when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (texel_ch.valid && texel_ch.ready) || (pixel_ch.valid && pixel_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [gtfc_pkg::PIX_W-1:0]     list[$];
    logic [gtfc_pkg::PIX_W-1:0]     t;
    logic [gtfc_pkg::BRIGHT_W-1:0]  b;
    logic [gtfc_pkg::PIX_W-1:0]     color;
    int                             leftover;

    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= gtfc_pkg::CFG_MODE;
    cfg_data       <= '0;
    texel_ch.valid <= 1'b0;
    texel_ch.texel <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: registers at their reset values, so 565 to 1555 first.
    // Cover both extremes, the green key, full green, and the dropped low green bit.
    list = '{16'h0000, 16'hFFFF, gtfc_pkg::KEY_GREEN, 16'h07C0, 16'h0020, 16'hF81F};
    send_list(list);

    // Mono: only bit 0 matters.
    wait_pipeline_empty();
    configure(gtfc_pkg::MODE_MONO, gtfc_pkg::BRIGHT_RESET, 16'h1234);
    list = '{16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF};
    send_list(list);

    wait_pipeline_empty();
    configure(gtfc_pkg::MODE_PASS4444, gtfc_pkg::BRIGHT_RESET, gtfc_pkg::MONO_RESET);
    list = '{16'h0000, 16'hFFFF, 16'hA5A5};
    send_list(list);

    // Gradient at unit brightness: key, brightest, darkest, full green.
    wait_pipeline_empty();
    configure(gtfc_pkg::MODE_GRAD, 7'd10, gtfc_pkg::MONO_RESET);
    list = '{gtfc_pkg::KEY_GREEN, 16'hFFFF, 16'h0000, 16'h07C0};
    send_list(list);

    // Zero brightness: every texel but the key goes to bare alpha.
    wait_pipeline_empty();
    configure(gtfc_pkg::MODE_GRAD, 7'd0, gtfc_pkg::MONO_RESET);
    list = '{16'hFFFF, 16'h0021};
    send_list(list);

    // r=7, b=10 gives luminance 320; at 100 tenths that lands exactly on full scale.
    wait_pipeline_empty();
    configure(gtfc_pkg::MODE_GRAD, 7'd100, gtfc_pkg::MONO_RESET);
    list = '{16'h380A, 16'h380B};
    send_list(list);

    // Top brightness: saturation.
    wait_pipeline_empty();
    configure(gtfc_pkg::MODE_GRAD, 7'd127, gtfc_pkg::MONO_RESET);
    list = '{16'hFFFF, 16'h001F};
    send_list(list);

    // Random phases: cycle through the modes, brightness and colour at times pinned
    // to their extremes. Some phases run with no idling at all; two start with a
    // long receiver hold-off while the sender keeps offering beats.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_pipeline_empty();
      b     = (phase == 3) ? 7'd0 : (phase == 7) ? 7'd127 :
              gtfc_pkg::BRIGHT_W'($urandom_range(0, 127));
      color = (phase == 0) ? 16'h0000 : (phase == 4) ? 16'hFFFF :
              gtfc_pkg::PIX_W'($urandom);
      configure(gtfc_pkg::mode_t'(phase % 4), b, color);
      steady_flow = (phase % 3 == 1);
      if (phase == 2 || phase == 9)
        hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 15))
          0:       t = gtfc_pkg::KEY_GREEN;
          // one bit off the key
          1:       t = gtfc_pkg::KEY_GREEN ^ (16'd1 << $urandom_range(0, 15));
          2:       t = 16'hFFFF;
          3:       t = 16'h0000;
          default: t = gtfc_pkg::PIX_W'($urandom);
        endcase
        send_texel(t, steady_flow ? 0 : idle_len());
      end
    end
    steady_flow = 1'b0;

    wait_pipeline_empty();
    leftover = board.report_leftover();
    if (board.errors == 0 && leftover == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
